// ----- design/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon crossing-number block.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

  // Coordinate format, fixed by the field widths.
  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COUNT_BITS       = 7;
  localparam int SLOT_BITS        = 6;
  localparam int COUNT_RESET_VAL  = 4;

  // Configuration port.
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;
  localparam logic [REG_IDX_BITS-1:0] REG_VERTEX_COUNT = 1'b0;

  // Operation codes of an input word.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TEST  = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vtx_t;

  // Query token handed from cell to cell. The products of one cell are
  // compared by the next cell, so the pending flag marks an edge whose
  // crossing decision is still open.
  typedef struct packed {
    logic   valid;
    coord_t px;
    coord_t py;
    coord_t xmin;
    coord_t xmax;
    coord_t ymin;
    coord_t ymax;
    logic   parity;
    logic   pend;
    prod_t  lhs;
    prod_t  rhs;
  } tok_t;

endpackage

`default_nettype wire

// ----- design/point_in_polygon_test_top.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_test_top
// Point-in-polygon test by crossing number over a chain of vertex cells.
// ----------------------------------------------------------------------------
// A test word holds the input until its result has been loaded into the output
// register, so only one test is in the chain at a time, and a stalled result
// channel keeps the input blocked.
// The query token walks every cell of the chain, one cell per clock, whatever
// vertex_count is; vertex writes never block the input.
// Reset clears the handshake state and sets vertex_count to 4 (at most the
// store depth); vertex registers keep their contents, undefined until written.
`default_nettype none

module point_in_polygon_test_top #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input channel.
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              op,
  input  wire logic [pip_pkg::SLOT_BITS-1:0]     vertex_slot,
  input  wire logic signed [pip_pkg::COORD_BITS-1:0] coord_x,
  input  wire logic signed [pip_pkg::COORD_BITS-1:0] coord_y,
  // Result channel.
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   inside_res,
  // Configuration port.
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pip_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [pip_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [pip_pkg::APB_DATA_BITS-1:0]      prdata,
  output logic                                   pready
);

  // The count register resets to four, or to the store depth if smaller.
  localparam int COUNT_INIT = (pip_pkg::COUNT_RESET_VAL > MAX_VERTICES) ?
                              MAX_VERTICES : pip_pkg::COUNT_RESET_VAL;

  logic [pip_pkg::COUNT_BITS-1:0] vertex_count;
  logic [pip_pkg::COUNT_BITS-1:0] wr_count;
  logic                           cfg_wr;

  logic          accept;
  logic          wr_en;
  logic          q_acc;
  logic          busy;
  logic          busy_next;
  logic          load_out;
  pip_pkg::vtx_t wr_vtx;

  pip_pkg::vtx_t vtx [MAX_VERTICES];
  pip_pkg::tok_t tok [MAX_VERTICES+1];
  pip_pkg::tok_t tok_head;
  pip_pkg::tok_t tok0_next;
  pip_pkg::tok_t te;

  logic end_cross;
  logic outside;
  logic end_inside;
  logic hold_valid;
  logic hold_inside;

  // --------------------------------------------------------------------------
  // Configuration port. Any write to the register index of vertex_count
  // stores the low seven data bits, saturated at the store depth.
  // --------------------------------------------------------------------------
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready &&
                    (paddr[pip_pkg::APB_ADDR_BITS-1:2] == pip_pkg::REG_VERTEX_COUNT);
  assign wr_count = pwdata[pip_pkg::COUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= pip_pkg::COUNT_BITS'(COUNT_INIT);
    end else if (cfg_wr) begin
      vertex_count <= (32'(wr_count) > MAX_VERTICES) ?
                      pip_pkg::COUNT_BITS'(MAX_VERTICES) : wr_count;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[pip_pkg::APB_ADDR_BITS-1:2] == pip_pkg::REG_VERTEX_COUNT) begin
      prdata[pip_pkg::COUNT_BITS-1:0] = vertex_count;
    end
  end

  // --------------------------------------------------------------------------
  // Input side. A test word holds the input until its result has entered
  // the output register; vertex writes finish in the cycle they are taken.
  // --------------------------------------------------------------------------
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign wr_en    = accept && (op == pip_pkg::OP_WRITE);
  assign q_acc    = accept && (op == pip_pkg::OP_TEST);
  assign wr_vtx   = '{x: coord_x, y: coord_y};

  always_comb begin
    busy_next = busy;
    if (q_acc) begin
      busy_next = 1'b1;
    end else if (load_out) begin
      busy_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= busy_next;
    end
  end

  // The token enters the chain with an empty bounding box, which the used
  // cells widen as it passes them.
  always_comb begin
    tok0_next        = '0;
    tok0_next.valid  = q_acc;
    tok0_next.px     = coord_x;
    tok0_next.py     = coord_y;
    tok0_next.xmin   = pip_pkg::COORD_MAX;
    tok0_next.xmax   = pip_pkg::COORD_MIN;
    tok0_next.ymin   = pip_pkg::COORD_MAX;
    tok0_next.ymax   = pip_pkg::COORD_MIN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_head <= '0;
    end else begin
      tok_head <= tok0_next;
    end
  end

  assign tok[0] = tok_head;

  // --------------------------------------------------------------------------
  // Chain of cells. Cell k owns vertex k and handles the edge from vertex k
  // to vertex k+1, or back to vertex 0 when it is the last used cell.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    pip_cell #(
      .IDX (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (wr_en),
      .wr_slot (vertex_slot),
      .wr_vtx  (wr_vtx),
      .count   (vertex_count),
      .nxt     (vtx[(k + 1) % MAX_VERTICES]),
      .first   (vtx[0]),
      .tok_in  (tok[k]),
      .vtx     (vtx[k]),
      .tok_out (tok[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Chain end. The last edge's comparison is finished here, and the point is
  // rejected when it lies outside the bounding box. An empty polygon always
  // answers outside.
  // --------------------------------------------------------------------------
  assign te         = tok[MAX_VERTICES];
  assign end_cross  = te.pend && ($signed(te.lhs) >= $signed(te.rhs));
  assign outside    = (te.px < te.xmin) || (te.px > te.xmax) ||
                      (te.py < te.ymin) || (te.py > te.ymax);
  assign end_inside = (vertex_count != '0) && !outside && (te.parity ^ end_cross);

  // The output register takes a result when it is empty or being emptied.
  // If the consumer stalls as a result arrives, the result waits in a
  // holding register; only one test is ever in flight.
  assign load_out = (!out_valid || out_ready) && (hold_valid || te.valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (hold_valid) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end else begin
        out_valid  <= te.valid;
      end
    end else if (te.valid) begin
      hold_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      inside_res <= hold_valid ? hold_inside : end_inside;
    end else if (te.valid) begin
      hold_inside <= end_inside;
    end
  end

endmodule

`default_nettype wire

// ----- design/pip_cell.sv -----
// ----------------------------------------------------------------------------
// pip_cell
// One vertex register and one edge stage of the query chain.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_cell #(
  parameter int IDX = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [pip_pkg::SLOT_BITS-1:0] wr_slot,
  input  wire pip_pkg::vtx_t                 wr_vtx,
  input  wire logic [pip_pkg::COUNT_BITS-1:0] count,
  input  wire pip_pkg::vtx_t                 nxt,
  input  wire pip_pkg::vtx_t                 first,
  input  wire pip_pkg::tok_t                 tok_in,
  output pip_pkg::vtx_t                      vtx,
  output pip_pkg::tok_t                      tok_out
);

  logic                          active;
  logic                          wrap;
  pip_pkg::vtx_t                 b;
  logic                          swap;
  pip_pkg::coord_t               x1, y1, x2, y2;
  logic signed [pip_pkg::DIFF_BITS-1:0] dx, dy, qx, qy;
  pip_pkg::prod_t                lhs, rhs;
  logic                          vertical;
  logic                          in_span;
  logic                          crossed;
  pip_pkg::tok_t                 tok_next;

  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_slot) == IDX)) begin
      vtx <= wr_vtx;
    end
  end

  assign active = 32'(count) > IDX;
  assign wrap   = 32'(count) == (IDX + 1);

  always_comb begin
    b    = wrap ? first : nxt;
    swap = vtx.x > b.x;
    x1   = swap ? b.x : vtx.x;
    y1   = swap ? b.y : vtx.y;
    x2   = swap ? vtx.x : b.x;
    y2   = swap ? vtx.y : b.y;

    dx = pip_pkg::DIFF_BITS'(x2) - pip_pkg::DIFF_BITS'(x1);
    dy = pip_pkg::DIFF_BITS'(y2) - pip_pkg::DIFF_BITS'(y1);
    qx = pip_pkg::DIFF_BITS'(tok_in.px) - pip_pkg::DIFF_BITS'(x1);
    qy = pip_pkg::DIFF_BITS'(tok_in.py) - pip_pkg::DIFF_BITS'(y1);

    lhs = pip_pkg::PROD_BITS'(qy) * pip_pkg::PROD_BITS'(dx);
    rhs = pip_pkg::PROD_BITS'(qx) * pip_pkg::PROD_BITS'(dy);

    vertical = x1 == x2;
    in_span  = (tok_in.px >= x1) && (tok_in.px <= x2);

    // Finish the decision of the previous cell's edge.
    crossed = tok_in.pend && ($signed(tok_in.lhs) >= $signed(tok_in.rhs));

    tok_next        = tok_in;
    tok_next.parity = tok_in.parity ^ crossed;
    tok_next.pend   = active && !vertical && in_span;
    tok_next.lhs    = lhs;
    tok_next.rhs    = rhs;
    if (active) begin
      if (vtx.x < tok_in.xmin) tok_next.xmin = vtx.x;
      if (vtx.x > tok_in.xmax) tok_next.xmax = vtx.x;
      if (vtx.y < tok_in.ymin) tok_next.ymin = vtx.y;
      if (vtx.y > tok_in.ymax) tok_next.ymax = vtx.y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/pip_checker.sv -----
// ----------------------------------------------------------------------------
// pip_checker
// Port-level assertions for the point-in-polygon block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic op,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic inside_res
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(inside_res))
    else $error("result word changed while stalled");

  // A test occupies the block, so no word is taken in the next cycle.
  a_test_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (op == pip_pkg::OP_TEST) |=> !in_ready)
    else $error("input taken right after a test word");

  // Vertex writes never block the input.
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (op == pip_pkg::OP_WRITE) |=> in_ready)
    else $error("input blocked after a vertex write");

  // A new result frees the input in the same cycle.
  a_result_frees: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result delivered while input still blocked");

endmodule

bind point_in_polygon_test_top pip_checker u_pip_checker (.*);

`default_nettype wire
